// ===== hdl/nbdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbdc_pkg
// Shared constants and types of the nearest-base delta classifier.
// ----------------------------------------------------------------------------
package nbdc_pkg;

  // Table geometry
  localparam int NUM_BASES       = 64;
  localparam int IDX_W           = 6;
  localparam int WORDS_PER_BLOCK = 16;
  localparam int POS_W           = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
  localparam int CNT_W           = 5;

  // Field widths
  localparam int WORD_W  = 32;
  localparam int LIMIT_W = 15;
  localparam int PACK_W  = 16;

  // Running best magnitude before the first compare
  localparam logic [WORD_W-1:0] NO_MATCH_MAG = 32'hFFFF_FFFF;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

  // APB register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_DELTA_LIMIT = 1'b0;

  // Input beat kinds
  typedef enum logic {
    ACT_LOAD     = 1'b0,
    ACT_CLASSIFY = 1'b1
  } action_e;

  // Winner of one table scan
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] mag;
  } scan_res_t;

  // Record memory control
  typedef struct packed {
    logic             clr;
    logic [IDX_W-1:0] clr_idx;
    logic             rd;
    logic [IDX_W-1:0] rd_idx;
    logic             commit;
  } rec_ctrl_t;

  // Per-block statistics of the current word
  typedef struct packed {
    logic [CNT_W-1:0] inliers;
    logic [CNT_W-1:0] outliers;
    logic             same_run;
    logic             last;
  } stats_t;

endpackage

// ===== hdl/nbdc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbdc_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface nbdc_in_if import nbdc_pkg::*; ();
  logic              valid;
  logic              ready;
  action_e           action;
  logic [IDX_W-1:0]  base_index;
  logic [WORD_W-1:0] base_value;
  logic [WORD_W-1:0] cls_word;

  modport source (output valid, action, base_index, base_value, cls_word, input ready);
  modport sink   (input valid, action, base_index, base_value, cls_word, output ready);
endinterface

interface nbdc_out_if import nbdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         nearest_index;
  logic [WORD_W-1:0]        nearest_base;
  logic signed [WORD_W-1:0] delta;
  logic                     is_inlier;
  logic signed [PACK_W-1:0] packed_delta;
  logic [WORD_W-1:0]        outlier_value;
  logic [CNT_W-1:0]         inl_total;
  logic [CNT_W-1:0]         outl_total;
  logic                     same_run;
  logic                     last_of_block;
  logic [LIMIT_W-1:0]       base_largest_delta;

  modport source (output valid, nearest_index, nearest_base, delta, is_inlier, packed_delta,
                  outlier_value, inl_total, outl_total, same_run, last_of_block,
                  base_largest_delta, input ready);
  modport sink   (input valid, nearest_index, nearest_base, delta, is_inlier, packed_delta,
                  outlier_value, inl_total, outl_total, same_run, last_of_block,
                  base_largest_delta, output ready);
endinterface

// ===== hdl/nbdc_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbdc_scan
// Base table memory and nearest-base search, one entry read per cycle.
// ----------------------------------------------------------------------------
module nbdc_scan import nbdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  wr_idx_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic              start_i,
  input  logic [WORD_W-1:0] word_i,
  output logic              done_o,
  output scan_res_t         best_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BASES - 1);

  logic [WORD_W-1:0] base_mem [NUM_BASES];

  logic              issue_q;
  logic [IDX_W-1:0]  addr_q;
  logic [WORD_W-1:0] rd_data_q;
  logic              s1_vld_q, s1_last_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic              s2_vld_q, s2_last_q;
  logic [IDX_W-1:0]  s2_idx_q;
  logic [WORD_W-1:0] s2_base_q, s2_delta_q;
  logic              done_q;
  scan_res_t         best_q;
  logic [WORD_W-1:0] s2_mag;

  // Memory: load writes, scan reads with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      base_mem[wr_idx_i] <= wr_data_i;
    end
    if (issue_q) begin
      rd_data_q <= base_mem[addr_q];
    end
  end

  // Magnitude of the wrapped delta, 2^31 stays unsigned
  assign s2_mag = s2_delta_q[WORD_W-1] ? (WORD_W'(0) - s2_delta_q) : s2_delta_q;

  // Address sequencer and compare pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q    <= 1'b0;
      addr_q     <= '0;
      s1_vld_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_idx_q   <= '0;
      s2_vld_q   <= 1'b0;
      s2_last_q  <= 1'b0;
      s2_idx_q   <= '0;
      s2_base_q  <= '0;
      s2_delta_q <= '0;
      done_q     <= 1'b0;
      best_q     <= '0;
    end else begin
      // read issue
      if (start_i) begin
        issue_q <= 1'b1;
        addr_q  <= '0;
      end else if (issue_q) begin
        addr_q <= addr_q + IDX_W'(1);
        if (addr_q == LAST_IDX) begin
          issue_q <= 1'b0;
        end
      end
      s1_vld_q  <= issue_q;
      s1_last_q <= issue_q && (addr_q == LAST_IDX);
      s1_idx_q  <= addr_q;
      // difference stage
      s2_vld_q   <= s1_vld_q;
      s2_last_q  <= s1_last_q;
      s2_idx_q   <= s1_idx_q;
      s2_base_q  <= rd_data_q;
      s2_delta_q <= rd_data_q - word_i;
      // strict less keeps the first of equal candidates
      if (start_i) begin
        best_q.mag <= NO_MATCH_MAG;
      end else if (s2_vld_q && (s2_mag < best_q.mag)) begin
        best_q.idx   <= s2_idx_q;
        best_q.base  <= s2_base_q;
        best_q.delta <= s2_delta_q;
        best_q.mag   <= s2_mag;
      end
      done_q <= s2_vld_q && s2_last_q;
    end
  end

  assign done_o = done_q;
  assign best_o = best_q;

endmodule

// ===== hdl/nbdc_record.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbdc_record
// Largest-delta record memory with read-modify-write of the winning entry.
// ----------------------------------------------------------------------------
module nbdc_record import nbdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rec_ctrl_t          ctrl_i,
  input  logic [WORD_W-1:0]  mag_i,
  input  logic [LIMIT_W-1:0] limit_i,
  output logic [LIMIT_W-1:0] rec_o
);

  logic [LIMIT_W-1:0] rec_mem [NUM_BASES];
  logic [NUM_BASES-1:0] valid_q;
  logic [LIMIT_W-1:0] rd_data_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   idx_q;
  logic [LIMIT_W-1:0] old_rec;
  logic [WORD_W-1:0]  limit_ext;

  // Memory port: read on request, write back on commit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_data_q <= rec_mem[ctrl_i.rd_idx];
    end
    if (ctrl_i.commit) begin
      rec_mem[idx_q] <= rec_o;
    end
  end

  // Valid bits: an entry reads as zero after reset or a base load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (ctrl_i.rd) begin
        rd_vld_q <= valid_q[ctrl_i.rd_idx];
        idx_q    <= ctrl_i.rd_idx;
      end
      if (ctrl_i.clr) begin
        valid_q[ctrl_i.clr_idx] <= 1'b0;
      end else if (ctrl_i.commit) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  // Capped maximum update
  assign old_rec   = rd_vld_q ? rd_data_q : '0;
  assign limit_ext = WORD_W'(limit_i);

  always_comb begin
    if (mag_i >= limit_ext) begin
      rec_o = limit_i;
    end else if (mag_i > WORD_W'(old_rec)) begin
      rec_o = mag_i[LIMIT_W-1:0];
    end else begin
      rec_o = old_rec;
    end
  end

endmodule

// ===== hdl/nbdc_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbdc_stats
// Per-block word position, inlier/outlier counts and all-equal tracking.
// ----------------------------------------------------------------------------
module nbdc_stats import nbdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  logic [WORD_W-1:0] word_i,
  input  logic              inlier_i,
  output stats_t            stats_o
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORDS_PER_BLOCK - 1);

  logic [POS_W-1:0]  pos_q;
  logic [CNT_W-1:0]  inl_q, outl_q;
  logic              all_eq_q;
  logic [WORD_W-1:0] prev_q;
  logic              first;
  logic [CNT_W-1:0]  inl_base, outl_base;

  // Counts restart on the first word of a block
  assign first     = (pos_q == '0);
  assign inl_base  = first ? '0 : inl_q;
  assign outl_base = first ? '0 : outl_q;

  always_comb begin
    stats_o.inliers  = inl_base + CNT_W'(inlier_i);
    stats_o.outliers = outl_base + CNT_W'(!inlier_i);
    stats_o.same_run = first ? 1'b1 : (all_eq_q && (prev_q == word_i));
    stats_o.last     = (pos_q == LAST_POS);
  end

  // Commit on each delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      inl_q    <= '0;
      outl_q   <= '0;
      all_eq_q <= 1'b1;
      prev_q   <= '0;
    end else if (upd_i) begin
      pos_q    <= stats_o.last ? '0 : pos_q + POS_W'(1);
      inl_q    <= stats_o.inliers;
      outl_q   <= stats_o.outliers;
      all_eq_q <= stats_o.same_run;
      prev_q   <= word_i;
    end
  end

endmodule

// ===== hdl/nearest_base_delta_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_base_delta_classifier_core
// Classifies words against a 64-entry global base table.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake              | Beat
//  in_i    | in  | valid/ready            | load base or classify word
//  out_o   | out | valid/ready            | one result per classify beat
//  APB     | in  | psel/penable/pwrite    | delta_limit at byte address 0
//
//  A classify beat reads the base memory one entry per cycle, then reads
//  the record memory and writes it back. After reset all records read as
//  zero at once. A finished result waits in the output register; a new
//  beat is accepted meanwhile, and a classify beat stalls at write-back
//  until that register frees.
// ----------------------------------------------------------------------------
module nearest_base_delta_classifier_core import nbdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  nbdc_in_if.sink            in_i,
  nbdc_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REC
  } state_e;

  state_e             state_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [WORD_W-1:0]  word_q;

  logic      in_acc, out_free, is_load, is_class, commit, inlier;
  logic      scan_done;
  scan_res_t best;
  rec_ctrl_t rec_ctrl;
  logic [LIMIT_W-1:0] rec;
  stats_t    stats;

  // Output register
  logic                     ov_q;
  logic [IDX_W-1:0]         o_idx_q;
  logic [WORD_W-1:0]        o_base_q, o_delta_q, o_outl_q;
  logic                     o_inl_q, o_alleq_q, o_last_q;
  logic [PACK_W-1:0]        o_pack_q;
  logic [CNT_W-1:0]         o_icnt_q, o_ocnt_q;
  logic [LIMIT_W-1:0]       o_rec_q;

  // APB register file
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_DELTA_LIMIT) ? PDATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[PADDR_W-1] == REG_DELTA_LIMIT)) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // Handshake decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_load    = in_acc && (in_i.action == ACT_LOAD);
  assign is_class   = in_acc && (in_i.action == ACT_CLASSIFY);
  assign out_free   = !ov_q || out_o.ready;
  assign commit     = (state_q == ST_REC) && out_free;
  assign inlier     = (best.mag <= WORD_W'(limit_q));

  // Base table and search
  nbdc_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (is_load),
    .wr_idx_i  (in_i.base_index),
    .wr_data_i (in_i.base_value),
    .start_i   (is_class),
    .word_i    (word_q),
    .done_o    (scan_done),
    .best_o    (best)
  );

  // Record memory control
  always_comb begin
    rec_ctrl.clr     = is_load;
    rec_ctrl.clr_idx = in_i.base_index;
    rec_ctrl.rd      = scan_done;
    rec_ctrl.rd_idx  = best.idx;
    rec_ctrl.commit  = commit;
  end

  nbdc_record u_record (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rec_ctrl),
    .mag_i   (best.mag),
    .limit_i (limit_q),
    .rec_o   (rec)
  );

  nbdc_stats u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (commit),
    .word_i   (word_q),
    .inlier_i (inlier),
    .stats_o  (stats)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      word_q    <= '0;
      ov_q      <= 1'b0;
      o_idx_q   <= '0;
      o_base_q  <= '0;
      o_delta_q <= '0;
      o_outl_q  <= '0;
      o_inl_q   <= 1'b0;
      o_alleq_q <= 1'b0;
      o_last_q  <= 1'b0;
      o_pack_q  <= '0;
      o_icnt_q  <= '0;
      o_ocnt_q  <= '0;
      o_rec_q   <= '0;
    end else begin
      // a commit refills the output register, an accepted beat empties it
      if (commit) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (is_class) begin
            word_q  <= in_i.cls_word;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_REC;
          end
        end
        ST_REC: begin
          if (commit) begin
            o_idx_q   <= best.idx;
            o_base_q  <= best.base;
            o_delta_q <= best.delta;
            o_inl_q   <= inlier;
            o_pack_q  <= inlier ? best.delta[PACK_W-1:0] : '0;
            o_outl_q  <= inlier ? '0 : word_q;
            o_icnt_q  <= stats.inliers;
            o_ocnt_q  <= stats.outliers;
            o_alleq_q <= stats.same_run;
            o_last_q  <= stats.last;
            o_rec_q   <= rec;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid              = ov_q;
  assign out_o.nearest_index      = o_idx_q;
  assign out_o.nearest_base       = o_base_q;
  assign out_o.delta              = o_delta_q;
  assign out_o.is_inlier          = o_inl_q;
  assign out_o.packed_delta       = o_pack_q;
  assign out_o.outlier_value      = o_outl_q;
  assign out_o.inl_total          = o_icnt_q;
  assign out_o.outl_total         = o_ocnt_q;
  assign out_o.same_run           = o_alleq_q;
  assign out_o.last_of_block      = o_last_q;
  assign out_o.base_largest_delta = o_rec_q;

endmodule
